/* design/pcc_pkg.sv */
// package for the parallel camera capture block
// types, register map, phase and result codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

    localparam int unsigned SpinW  = 20;
    localparam int unsigned ColW   = 12;
    localparam int unsigned RowW   = 10;
    localparam int unsigned AddrW  = 4;
    localparam int unsigned DataW  = 32;

    localparam logic [SpinW-1:0] SPIN_LIMIT_RST = 20'd500000;
    localparam logic [ColW-1:0]  BYTES_ROW_RST  = 12'd320;
    localparam logic [RowW-1:0]  ROWS_FRAME_RST = 10'd120;

    typedef enum logic [1:0] {
        REG_SPIN_LIMIT = 2'd0,
        REG_BYTES_ROW  = 2'd1,
        REG_ROWS_FRAME = 2'd2,
        REG_UNUSED     = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_VSYNC_HI = 3'd0,
        PH_VSYNC_LO = 3'd1,
        PH_HREF_HI  = 3'd2,
        PH_PCLK_LO  = 3'd3,
        PH_PCLK_HI  = 3'd4,
        PH_HREF_LO  = 3'd5,
        PH_IDLE     = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_TIMEOUT = 2'd2
    } t_kind;

    typedef struct packed {
        logic [SpinW-1:0] spin_limit;
        logic [ColW-1:0]  row_bytes;
        logic [RowW-1:0]  rows_per_frame;
    } t_cfg;

    typedef struct packed {
        logic        start_req;
        logic        vsync_level;
        logic        href_level;
        logic        pclk_level;
        logic [15:0] pin_word;
    } t_item;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] pixel_byte;
        logic       end_of_row;
        logic [2:0] failed_phase;
    } t_result;

    function automatic logic [7:0] remap_byte(input logic [15:0] pins);
        remap_byte = {pins[15:10], pins[3:2]};
    endfunction

endpackage

`default_nettype wire

/* design/parallel_camera_capture_top.sv */
// top level of the parallel camera capture block: input register, sequencer, result register
// depends on pcc_pkg, pcc_cfg and pcc_seq
// an accepted item waits in the input register until the output is free, then its result is registered
// throughput: one item per cycle while no stalled result waits, as the sequencer updates on every advance
// input stall rises only while the input register is full and a stalled result waits
// reset (synchronous, active low) empties both registers, idles phase, reloads config
`timescale 1ns / 1ps
`default_nettype none

module parallel_camera_capture_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pcc_pkg::AddrW-1:0]   paddr,
    input  wire logic [pcc_pkg::DataW-1:0]   pwdata,
    output logic      [pcc_pkg::DataW-1:0]   prdata,
    output logic                             pready,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_start_req,
    input  wire logic                        i_vsync_level,
    input  wire logic                        i_href_level,
    input  wire logic                        i_pclk_level,
    input  wire logic [15:0]                 i_pin_word,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [1:0]                  o_kind,
    output logic      [7:0]                  o_pixel_byte,
    output logic                             o_end_of_row,
    output logic      [2:0]                  o_failed_phase
);

    pcc_pkg::t_cfg    w_cfg;
    pcc_pkg::t_result w_res;
    pcc_pkg::t_item   r_in_item;
    logic             r_in_valid;
    pcc_pkg::t_result r_out;
    logic             w_out_free;
    logic             w_adv;
    logic             w_accept;

    pcc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pcc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (r_in_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign w_out_free = !r_out.valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item.start_req   <= i_start_req;
            r_in_item.vsync_level <= i_vsync_level;
            r_in_item.href_level  <= i_href_level;
            r_in_item.pclk_level  <= i_pclk_level;
            r_in_item.pin_word    <= i_pin_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (w_adv) begin
            r_out.valid <= w_res.valid;
        end else if (!i_out_stall) begin
            r_out.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.valid) begin
            r_out.kind         <= w_res.kind;
            r_out.pixel_byte   <= w_res.pixel_byte;
            r_out.end_of_row   <= w_res.end_of_row;
            r_out.failed_phase <= w_res.failed_phase;
        end
    end

    assign o_out_valid    = r_out.valid;
    assign o_kind         = r_out.kind;
    assign o_pixel_byte   = r_out.pixel_byte;
    assign o_end_of_row   = r_out.end_of_row;
    assign o_failed_phase = r_out.failed_phase;

endmodule

`default_nettype wire

/* design/pcc_cfg.sv */
// configuration registers behind the apb-style port
// uses pcc_pkg for register map, reset values and the config struct
`timescale 1ns / 1ps
`default_nettype none

module pcc_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pcc_pkg::AddrW-1:0]   paddr,
    input  wire logic [pcc_pkg::DataW-1:0]   pwdata,
    output logic      [pcc_pkg::DataW-1:0]   prdata,
    output logic                             pready,
    output pcc_pkg::t_cfg                    o_cfg
);

    pcc_pkg::t_cfg     r_cfg;
    pcc_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign w_idx  = pcc_pkg::t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spin_limit     <= pcc_pkg::SPIN_LIMIT_RST;
            r_cfg.row_bytes      <= pcc_pkg::BYTES_ROW_RST;
            r_cfg.rows_per_frame <= pcc_pkg::ROWS_FRAME_RST;
        end else if (w_wr) begin
            case (w_idx)
                pcc_pkg::REG_SPIN_LIMIT: begin
                    r_cfg.spin_limit <= pwdata[pcc_pkg::SpinW-1:0];
                end
                pcc_pkg::REG_BYTES_ROW: begin
                    r_cfg.row_bytes <= pwdata[pcc_pkg::ColW-1:0];
                end
                pcc_pkg::REG_ROWS_FRAME: begin
                    r_cfg.rows_per_frame <= pwdata[pcc_pkg::RowW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            pcc_pkg::REG_SPIN_LIMIT: begin
                prdata = {{(pcc_pkg::DataW-pcc_pkg::SpinW){1'b0}}, r_cfg.spin_limit};
            end
            pcc_pkg::REG_BYTES_ROW: begin
                prdata = {{(pcc_pkg::DataW-pcc_pkg::ColW){1'b0}}, r_cfg.row_bytes};
            end
            pcc_pkg::REG_ROWS_FRAME: begin
                prdata = {{(pcc_pkg::DataW-pcc_pkg::RowW){1'b0}}, r_cfg.rows_per_frame};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/pcc_seq.sv */
// capture sequencer: phase, spin, column and row state, one item per advance
// uses pcc_pkg for phase codes, item, config and result types
`timescale 1ns / 1ps
`default_nettype none

module pcc_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire pcc_pkg::t_item    i_item,
    input  wire pcc_pkg::t_cfg     i_cfg,
    output pcc_pkg::t_result       o_res
);

    pcc_pkg::t_phase               r_phase, n_phase;
    logic [pcc_pkg::SpinW-1:0]     r_spin, n_spin;
    logic [pcc_pkg::ColW-1:0]      r_col, n_col;
    logic [pcc_pkg::RowW-1:0]      r_row, n_row;

    logic [pcc_pkg::SpinW-1:0]     w_lim;
    logic [pcc_pkg::SpinW-1:0]     w_spin_inc;
    logic [pcc_pkg::ColW-1:0]      w_bpr;
    logic [pcc_pkg::RowW-1:0]      w_rpf;
    logic                          w_col_last;
    logic                          w_row_last;
    logic                          w_level;
    logic                          w_target;

    assign w_lim  = (i_cfg.spin_limit == '0) ? pcc_pkg::SpinW'(1) : i_cfg.spin_limit;
    assign w_bpr  = (i_cfg.row_bytes == '0) ? pcc_pkg::ColW'(1) : i_cfg.row_bytes;
    assign w_rpf  = (i_cfg.rows_per_frame == '0) ? pcc_pkg::RowW'(1) : i_cfg.rows_per_frame;
    assign w_spin_inc = r_spin + pcc_pkg::SpinW'(1);
    assign w_col_last = ({1'b0, r_col} + (pcc_pkg::ColW+1)'(1)) >= {1'b0, w_bpr};
    assign w_row_last = ({1'b0, r_row} + (pcc_pkg::RowW+1)'(1)) >= {1'b0, w_rpf};

    always_comb begin
        case (r_phase)
            pcc_pkg::PH_VSYNC_HI: begin
                w_level  = i_item.vsync_level;
                w_target = 1'b1;
            end
            pcc_pkg::PH_VSYNC_LO: begin
                w_level  = i_item.vsync_level;
                w_target = 1'b0;
            end
            pcc_pkg::PH_HREF_HI: begin
                w_level  = i_item.href_level;
                w_target = 1'b1;
            end
            pcc_pkg::PH_PCLK_LO: begin
                w_level  = i_item.pclk_level;
                w_target = 1'b0;
            end
            pcc_pkg::PH_PCLK_HI: begin
                w_level  = i_item.pclk_level;
                w_target = 1'b1;
            end
            default: begin
                w_level  = i_item.href_level;
                w_target = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_spin  = r_spin;
        n_col   = r_col;
        n_row   = r_row;
        o_res   = '0;
        if (r_phase == pcc_pkg::PH_IDLE || r_phase > pcc_pkg::PH_IDLE) begin
            n_phase = pcc_pkg::PH_IDLE;
            if (i_item.start_req) begin
                n_phase = pcc_pkg::PH_VSYNC_HI;
                n_spin  = '0;
                n_col   = '0;
                n_row   = '0;
            end
        end else if (w_level != w_target) begin
            if (w_spin_inc >= w_lim) begin
                o_res.valid        = 1'b1;
                o_res.kind         = pcc_pkg::KIND_TIMEOUT;
                o_res.failed_phase = r_phase;
                n_phase            = pcc_pkg::PH_IDLE;
                n_spin             = '0;
            end else begin
                n_spin = w_spin_inc;
            end
        end else begin
            n_spin = '0;
            case (r_phase)
                pcc_pkg::PH_VSYNC_HI: begin
                    n_phase = pcc_pkg::PH_VSYNC_LO;
                end
                pcc_pkg::PH_VSYNC_LO: begin
                    n_row   = '0;
                    n_phase = pcc_pkg::PH_HREF_HI;
                end
                pcc_pkg::PH_HREF_HI: begin
                    n_col   = '0;
                    n_phase = pcc_pkg::PH_PCLK_LO;
                end
                pcc_pkg::PH_PCLK_LO: begin
                    o_res.valid      = 1'b1;
                    o_res.kind       = pcc_pkg::KIND_DATA;
                    o_res.pixel_byte = pcc_pkg::remap_byte(i_item.pin_word);
                    o_res.end_of_row = w_col_last;
                    n_phase          = pcc_pkg::PH_PCLK_HI;
                end
                pcc_pkg::PH_PCLK_HI: begin
                    if (w_col_last) begin
                        n_col   = '0;
                        n_phase = pcc_pkg::PH_HREF_LO;
                    end else begin
                        n_col   = r_col + pcc_pkg::ColW'(1);
                        n_phase = pcc_pkg::PH_PCLK_LO;
                    end
                end
                default: begin
                    if (w_row_last) begin
                        n_row      = '0;
                        o_res.valid = 1'b1;
                        o_res.kind  = pcc_pkg::KIND_DONE;
                        n_phase     = pcc_pkg::PH_IDLE;
                    end else begin
                        n_row   = r_row + pcc_pkg::RowW'(1);
                        n_phase = pcc_pkg::PH_HREF_HI;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pcc_pkg::PH_IDLE;
            r_spin  <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_spin  <= n_spin;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

endmodule

`default_nettype wire

/* verif/tb_parallel_camera_capture_top.sv */
// self-checking testbench for parallel_camera_capture_top: random pin samples and stalls
// predicts every byte, frame done and timeout result; depends on pcc_pkg and the design files
`timescale 1ns / 1ps

module tb_parallel_camera_capture_top;

    typedef struct packed {
        pcc_pkg::t_kind kind;
        logic [7:0]     pixel_byte;
        logic           end_of_row;
        logic [2:0]     failed_phase;
    } t_cap_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [pcc_pkg::AddrW-1:0]    paddr = '0;
    logic [pcc_pkg::DataW-1:0]    pwdata = '0;
    logic [pcc_pkg::DataW-1:0]    prdata;
    logic                         pready;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic                         i_start_req = 1'b0;
    logic                         i_vsync_level = 1'b0;
    logic                         i_href_level = 1'b0;
    logic                         i_pclk_level = 1'b0;
    logic [15:0]                  i_pin_word = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [1:0]                   o_kind;
    logic [7:0]                   o_pixel_byte;
    logic                         o_end_of_row;
    logic [2:0]                   o_failed_phase;

    parallel_camera_capture_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_start_req    (i_start_req),
        .i_vsync_level  (i_vsync_level),
        .i_href_level   (i_href_level),
        .i_pclk_level   (i_pclk_level),
        .i_pin_word     (i_pin_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_pixel_byte   (o_pixel_byte),
        .o_end_of_row   (o_end_of_row),
        .o_failed_phase (o_failed_phase)
    );

    // pin samples waiting for the driver, predicted results waiting for the monitor
    pcc_pkg::t_item pin_samples_q[$];
    t_cap_result    capture_events_q[$];

    // predictor copy of the configuration and the sequencer state
    logic [pcc_pkg::SpinW-1:0] cfg_spin = pcc_pkg::SPIN_LIMIT_RST;
    logic [pcc_pkg::ColW-1:0]  cfg_bpr = pcc_pkg::BYTES_ROW_RST;
    logic [pcc_pkg::RowW-1:0]  cfg_rpf = pcc_pkg::ROWS_FRAME_RST;
    pcc_pkg::t_phase           cap_phase = pcc_pkg::PH_IDLE;
    logic [pcc_pkg::SpinW-1:0] spin_cnt = '0;
    logic [pcc_pkg::ColW-1:0]  col_cnt = '0;
    logic [pcc_pkg::RowW-1:0]  row_cnt = '0;

    bit             drv_hold = 1'b0;
    bit             in_taken = 1'b0;
    bit             out_taken = 1'b0;
    bit             calm = 1'b0;
    int             in_gap = 0;
    int             out_wait = 0;
    int             n_pushed = 0;
    int             n_items = 0;
    int             n_bytes = 0;
    int             n_done = 0;
    int             n_timeouts = 0;
    int             n_settings = 0;
    int             n_fail = 0;
    int             phase_end = 0;
    pcc_pkg::t_item drv_item;
    pcc_pkg::t_item obs_item;
    pcc_pkg::t_item tmp_item;
    t_cap_result    exp_res;

    always #5 i_clk = ~i_clk;

    function automatic int draw_wait();
        if (calm || $urandom_range(0, 2) != 0) return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic pcc_pkg::t_item rand_item();
        pcc_pkg::t_item it;
        it.start_req   = ($urandom_range(0, 7) == 0);
        it.vsync_level = 1'($urandom_range(0, 1));
        it.href_level  = 1'($urandom_range(0, 1));
        it.pclk_level  = 1'($urandom_range(0, 1));
        it.pin_word    = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    // random item whose level for the given wait either matches or misses
    function automatic pcc_pkg::t_item level_item(input pcc_pkg::t_phase ph, input bit hit);
        pcc_pkg::t_item it;
        it = rand_item();
        case (ph)
            pcc_pkg::PH_VSYNC_HI: it.vsync_level = hit;
            pcc_pkg::PH_VSYNC_LO: it.vsync_level = !hit;
            pcc_pkg::PH_HREF_HI:  it.href_level = hit;
            pcc_pkg::PH_PCLK_LO:  it.pclk_level = !hit;
            pcc_pkg::PH_PCLK_HI:  it.pclk_level = hit;
            default:              it.href_level = !hit;
        endcase
        return it;
    endfunction

    function automatic int draw_spins();
        int lim;
        lim = (cfg_spin == '0) ? 1 : int'(cfg_spin);
        if (lim <= 8 && $urandom_range(0, 24) == 0) return lim;
        if ($urandom_range(0, 3) != 0) return 0;
        return (lim <= 3) ? $urandom_range(0, lim - 1) : $urandom_range(1, 3);
    endfunction

    task automatic queue_item(input pcc_pkg::t_item it);
        pin_samples_q.push_back(it);
        n_pushed++;
    endtask

    task automatic push_wait(input pcc_pkg::t_phase ph, input int spins);
        repeat (spins) queue_item(level_item(ph, 1'b0));
        queue_item(level_item(ph, 1'b1));
    endtask

    task automatic push_frame();
        pcc_pkg::t_item it;
        int             bpr;
        int             rpf;
        bpr = (cfg_bpr == '0) ? 1 : int'(cfg_bpr);
        rpf = (cfg_rpf == '0) ? 1 : int'(cfg_rpf);
        it = rand_item();
        it.start_req = 1'b1;
        queue_item(it);
        push_wait(pcc_pkg::PH_VSYNC_HI, draw_spins());
        push_wait(pcc_pkg::PH_VSYNC_LO, draw_spins());
        for (int r = 0; r < rpf; r++) begin
            push_wait(pcc_pkg::PH_HREF_HI, draw_spins());
            for (int c = 0; c < bpr; c++) begin
                push_wait(pcc_pkg::PH_PCLK_LO, draw_spins());
                push_wait(pcc_pkg::PH_PCLK_HI, draw_spins());
            end
            push_wait(pcc_pkg::PH_HREF_LO, draw_spins());
        end
    endtask

    task automatic predict_capture(input pcc_pkg::t_item it);
        t_cap_result res;
        int unsigned lim;
        int unsigned bpr;
        int unsigned rpf;
        logic        lvl;
        logic        tgt;
        lim = (cfg_spin == '0) ? 1 : cfg_spin;
        bpr = (cfg_bpr == '0) ? 1 : cfg_bpr;
        rpf = (cfg_rpf == '0) ? 1 : cfg_rpf;
        res = '{kind: pcc_pkg::KIND_DATA, pixel_byte: 8'h00, end_of_row: 1'b0,
                failed_phase: 3'd0};
        if (cap_phase == pcc_pkg::PH_IDLE) begin
            if (it.start_req) begin
                cap_phase = pcc_pkg::PH_VSYNC_HI;
                spin_cnt = '0;
                col_cnt = '0;
                row_cnt = '0;
            end
        end else begin
            case (cap_phase)
                pcc_pkg::PH_VSYNC_HI: begin lvl = it.vsync_level; tgt = 1'b1; end
                pcc_pkg::PH_VSYNC_LO: begin lvl = it.vsync_level; tgt = 1'b0; end
                pcc_pkg::PH_HREF_HI:  begin lvl = it.href_level;  tgt = 1'b1; end
                pcc_pkg::PH_PCLK_LO:  begin lvl = it.pclk_level;  tgt = 1'b0; end
                pcc_pkg::PH_PCLK_HI:  begin lvl = it.pclk_level;  tgt = 1'b1; end
                default:              begin lvl = it.href_level;  tgt = 1'b0; end
            endcase
            if (lvl != tgt) begin
                spin_cnt = spin_cnt + 1'b1;
                if (spin_cnt >= lim) begin
                    res.kind = pcc_pkg::KIND_TIMEOUT;
                    res.failed_phase = cap_phase;
                    capture_events_q.push_back(res);
                    n_timeouts++;
                    cap_phase = pcc_pkg::PH_IDLE;
                    spin_cnt = '0;
                end
            end else begin
                spin_cnt = '0;
                case (cap_phase)
                    pcc_pkg::PH_VSYNC_HI: cap_phase = pcc_pkg::PH_VSYNC_LO;
                    pcc_pkg::PH_VSYNC_LO: begin
                        row_cnt = '0;
                        cap_phase = pcc_pkg::PH_HREF_HI;
                    end
                    pcc_pkg::PH_HREF_HI: begin
                        col_cnt = '0;
                        cap_phase = pcc_pkg::PH_PCLK_LO;
                    end
                    pcc_pkg::PH_PCLK_LO: begin
                        res.pixel_byte = {it.pin_word[15:10], it.pin_word[3:2]};
                        res.end_of_row = (col_cnt + 1 >= bpr);
                        capture_events_q.push_back(res);
                        n_bytes++;
                        cap_phase = pcc_pkg::PH_PCLK_HI;
                    end
                    pcc_pkg::PH_PCLK_HI: begin
                        if (col_cnt + 1 >= bpr) begin
                            col_cnt = '0;
                            cap_phase = pcc_pkg::PH_HREF_LO;
                        end else begin
                            col_cnt = col_cnt + 1'b1;
                            cap_phase = pcc_pkg::PH_PCLK_LO;
                        end
                    end
                    default: begin
                        if (row_cnt + 1 >= rpf) begin
                            row_cnt = '0;
                            res.kind = pcc_pkg::KIND_DONE;
                            capture_events_q.push_back(res);
                            n_done++;
                            cap_phase = pcc_pkg::PH_IDLE;
                        end else begin
                            row_cnt = row_cnt + 1'b1;
                            cap_phase = pcc_pkg::PH_HREF_HI;
                        end
                    end
                endcase
            end
        end
    endtask

    task automatic apb_write(input pcc_pkg::t_reg_idx idx,
                             input logic [pcc_pkg::DataW-1:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            pcc_pkg::REG_SPIN_LIMIT: cfg_spin = val[pcc_pkg::SpinW-1:0];
            pcc_pkg::REG_BYTES_ROW:  cfg_bpr = val[pcc_pkg::ColW-1:0];
            pcc_pkg::REG_ROWS_FRAME: cfg_rpf = val[pcc_pkg::RowW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_regs(input int unsigned spin, input int unsigned bpr,
                                input int unsigned rpf);
        logic [pcc_pkg::DataW-1:0] v;
        v = $urandom();
        v[pcc_pkg::SpinW-1:0] = spin[pcc_pkg::SpinW-1:0];
        apb_write(pcc_pkg::REG_SPIN_LIMIT, v);
        v = $urandom();
        v[pcc_pkg::ColW-1:0] = bpr[pcc_pkg::ColW-1:0];
        apb_write(pcc_pkg::REG_BYTES_ROW, v);
        v = $urandom();
        v[pcc_pkg::RowW-1:0] = rpf[pcc_pkg::RowW-1:0];
        apb_write(pcc_pkg::REG_ROWS_FRAME, v);
        n_settings++;
    endtask

    // walk the sequencer back to idle, then let every result and the pipeline drain
    task automatic finish_phase();
        do @(posedge i_clk); while (pin_samples_q.size() != 0 || drv_hold);
        while (cap_phase != pcc_pkg::PH_IDLE) begin
            pin_samples_q.push_back(level_item(cap_phase, 1'b1));
            do @(posedge i_clk); while (pin_samples_q.size() != 0 || drv_hold);
        end
        do @(posedge i_clk); while (capture_events_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (drv_hold && in_taken) drv_hold = 1'b0;
            in_taken = 1'b0;
            if (!drv_hold) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pin_samples_q.size() > 0) begin
                    drv_item = pin_samples_q.pop_front();
                    i_start_req <= drv_item.start_req;
                    i_vsync_level <= drv_item.vsync_level;
                    i_href_level <= drv_item.href_level;
                    i_pclk_level <= drv_item.pclk_level;
                    i_pin_word <= drv_item.pin_word;
                    drv_hold = 1'b1;
                    in_gap = draw_wait();
                end
            end
            i_in_valid <= drv_hold;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                out_taken = 1'b0;
                out_wait = draw_wait();
            end
            if (out_wait > 0) begin
                i_out_stall <= 1'b1;
                out_wait--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                in_taken = 1'b1;
                n_items++;
                obs_item = {i_start_req, i_vsync_level, i_href_level, i_pclk_level, i_pin_word};
                predict_capture(obs_item);
            end
            if (o_out_valid && !i_out_stall) begin
                out_taken = 1'b1;
                if (capture_events_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected result: kind %0d byte %02h eor %0b phase %0d",
                                 o_kind, o_pixel_byte, o_end_of_row, o_failed_phase);
                end else begin
                    exp_res = capture_events_q.pop_front();
                    if (o_kind !== exp_res.kind || o_pixel_byte !== exp_res.pixel_byte ||
                        o_end_of_row !== exp_res.end_of_row ||
                        o_failed_phase !== exp_res.failed_phase) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display({"result mismatch: expected kind %0d byte %02h eor %0b ",
                                      "phase %0d, got kind %0d byte %02h eor %0b phase %0d"},
                                     exp_res.kind, exp_res.pixel_byte, exp_res.end_of_row,
                                     exp_res.failed_phase, o_kind, o_pixel_byte,
                                     o_end_of_row, o_failed_phase);
                    end
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("parallel_camera_capture_top regression: fail");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero registers act as one: single byte frames, first miss times out
        program_regs(0, 0, 0);
        apb_write(pcc_pkg::REG_UNUSED, $urandom());
        tmp_item = rand_item();
        tmp_item.start_req = 1'b1;
        queue_item(tmp_item);
        push_wait(pcc_pkg::PH_VSYNC_HI, 0);
        push_wait(pcc_pkg::PH_VSYNC_LO, 0);
        push_wait(pcc_pkg::PH_HREF_HI, 0);
        tmp_item = level_item(pcc_pkg::PH_PCLK_LO, 1'b1);
        tmp_item.pin_word = 16'hFFFF;
        queue_item(tmp_item);
        push_wait(pcc_pkg::PH_PCLK_HI, 0);
        push_wait(pcc_pkg::PH_HREF_LO, 0);
        // second frame with start held high while busy
        tmp_item = rand_item();
        tmp_item.start_req = 1'b1;
        queue_item(tmp_item);
        for (int k = 0; k < 6; k++) begin
            tmp_item = level_item(pcc_pkg::t_phase'(k), 1'b1);
            tmp_item.start_req = 1'b1;
            if (k == pcc_pkg::PH_PCLK_LO) tmp_item.pin_word = 16'h0000;
            queue_item(tmp_item);
        end
        tmp_item = rand_item();
        tmp_item.start_req = 1'b1;
        queue_item(tmp_item);
        push_wait(pcc_pkg::PH_VSYNC_HI, 1);
        finish_phase();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: program_regs(20'hFFFFF, $urandom_range(1, 8), $urandom_range(1, 4));
                1: program_regs(1, 1, $urandom_range(1, 4));
                default: program_regs($urandom_range(0, 1) ? $urandom_range(2, 8)
                                                           : $urandom_range(9, 1048575),
                                      $urandom_range(1, 12), $urandom_range(1, 4));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            phase_end = n_pushed + 210;
            while (n_pushed < phase_end) begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 4)) queue_item(rand_item());
                push_frame();
            end
            finish_phase();
        end

        // widest line and tallest frame, cut short by a pixel clock timeout
        calm = 1'b0;
        program_regs(3, 4095, 1023);
        tmp_item = rand_item();
        tmp_item.start_req = 1'b1;
        queue_item(tmp_item);
        push_wait(pcc_pkg::PH_VSYNC_HI, 0);
        push_wait(pcc_pkg::PH_VSYNC_LO, 0);
        push_wait(pcc_pkg::PH_HREF_HI, 0);
        repeat (3) begin
            push_wait(pcc_pkg::PH_PCLK_LO, 0);
            push_wait(pcc_pkg::PH_PCLK_HI, 0);
        end
        repeat (3) queue_item(level_item(pcc_pkg::PH_PCLK_LO, 1'b0));
        finish_phase();

        $display("accepted %0d pin samples over %0d register settings", n_items, n_settings);
        $display("checked %0d bytes, %0d completed frames, %0d timeouts; %0d failures",
                 n_bytes, n_done, n_timeouts, n_fail);
        if (n_fail == 0 && capture_events_q.size() == 0) begin
            $display("parallel_camera_capture_top regression: pass");
        end else begin
            $display("parallel_camera_capture_top regression: fail");
        end
        $finish;
    end

endmodule
